### design/ltl_pkg.sv
// ----------------------------------------------------------------------------
// ltl_pkg: shared types and constants of the Lisp token lexer
// Token layout, kind and operator codes, character classes and keyword lookup.
// ----------------------------------------------------------------------------
package ltl_pkg;

	localparam int NAME_CHARS_DEF  = 8;
	localparam int NUMBER_BITS_DEF = 32;
	localparam int QUEUE_DEPTH     = 8;

	localparam int CHAR_W   = 8;
	localparam int KIND_W   = 3;
	localparam int NUMBER_W = 32;
	localparam int OP_W     = 4;
	localparam int CHARS_W  = 64;
	localparam int LEN_W    = 4;
	localparam int KW_W     = 3;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_INT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NAME  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_OP    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_ERR   = 3'd6;

	// operator codes
	localparam logic [OP_W-1:0] OP_ADD = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV = 4'd3;
	localparam logic [OP_W-1:0] OP_EQ  = 4'd4;
	localparam logic [OP_W-1:0] OP_LT  = 4'd5;
	localparam logic [OP_W-1:0] OP_LE  = 4'd6;
	localparam logic [OP_W-1:0] OP_GT  = 4'd7;
	localparam logic [OP_W-1:0] OP_GE  = 4'd8;

	// keyword codes
	localparam logic [KW_W-1:0] KW_NONE  = 3'd0;
	localparam logic [KW_W-1:0] KW_IF    = 3'd1;
	localparam logic [KW_W-1:0] KW_T     = 3'd2;
	localparam logic [KW_W-1:0] KW_NIL   = 3'd3;
	localparam logic [KW_W-1:0] KW_SETQ  = 3'd4;
	localparam logic [KW_W-1:0] KW_DEFUN = 3'd5;

	// keyword spellings, first character in the low byte
	localparam logic [CHARS_W-1:0] KW_IF_CHARS    = 64'h6669;
	localparam logic [CHARS_W-1:0] KW_T_CHARS     = 64'h74;
	localparam logic [CHARS_W-1:0] KW_NIL_CHARS   = 64'h6C696E;
	localparam logic [CHARS_W-1:0] KW_SETQ_CHARS  = 64'h71746573;
	localparam logic [CHARS_W-1:0] KW_DEFUN_CHARS = 64'h6E75666564;

	// characters
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
	localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
	localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

	typedef enum logic [6:0] {
		MODE_IDLE   = 7'b0000001,
		MODE_NUMBER = 7'b0000010,
		MODE_NAME   = 7'b0000100,
		MODE_MINUS  = 7'b0001000,
		MODE_LT     = 7'b0010000,
		MODE_GT     = 7'b0100000,
		MODE_ERROR  = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
	} text_t;

	typedef struct packed {
		logic [KIND_W-1:0]          kind;
		logic signed [NUMBER_W-1:0] number;
		logic [OP_W-1:0]            op_code;
		logic [CHARS_W-1:0]         name_chars;
		logic [LEN_W-1:0]           name_length;
		logic                       name_truncated;
		logic [KW_W-1:0]            keyword;
		logic [CHAR_W-1:0]          bad_char;
		logic                       last;
	} token_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] l;
		l = c | CASE_BIT;
		return (l >= 8'h61) && (l <= 8'h7A);
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [KW_W-1:0] keyword_of(input logic [CHARS_W-1:0] chars,
			input logic [LEN_W-1:0] len);
		logic [KW_W-1:0] kw;
		if (len == 4'd2 && chars == KW_IF_CHARS) begin
			kw = KW_IF;
		end else if (len == 4'd1 && chars == KW_T_CHARS) begin
			kw = KW_T;
		end else if (len == 4'd3 && chars == KW_NIL_CHARS) begin
			kw = KW_NIL;
		end else if (len == 4'd4 && chars == KW_SETQ_CHARS) begin
			kw = KW_SETQ;
		end else if (len == 4'd5 && chars == KW_DEFUN_CHARS) begin
			kw = KW_DEFUN;
		end else begin
			kw = KW_NONE;
		end
		return kw;
	endfunction

endpackage

### design/ltl_stream_if.sv
// ----------------------------------------------------------------------------
// ltl_stream_if: valid/ready stream channel
// One request moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ltl_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/ltl_step.sv
// ----------------------------------------------------------------------------
// ltl_step: one lexer step
// Combinational next state and up to two tokens for one character.
// ----------------------------------------------------------------------------
module ltl_step import ltl_pkg::*; #(
	parameter int NAME_CHARS  = NAME_CHARS_DEF,
	parameter int NUMBER_BITS = NUMBER_BITS_DEF,
	localparam int CNT_W = $clog2(NAME_CHARS + 1)
) (
	input  logic [CHAR_W-1:0]       ch,
	input  mode_t                   mode,
	input  logic [NUMBER_BITS-1:0]  acc,
	input  logic                    neg,
	input  logic [8*NAME_CHARS-1:0] nbuf,
	input  logic [CNT_W-1:0]        ncnt,
	input  logic                    novf,
	output mode_t                   mode_nxt,
	output logic [NUMBER_BITS-1:0]  acc_nxt,
	output logic                    neg_nxt,
	output logic [8*NAME_CHARS-1:0] nbuf_nxt,
	output logic [CNT_W-1:0]        ncnt_nxt,
	output logic                    novf_nxt,
	output token_t                  res0,
	output token_t                  res1,
	output logic [1:0]              res_n
);

	logic [NUMBER_BITS-1:0]  digit;
	logic [CHAR_W-1:0]       lc;
	logic [NUMBER_BITS-1:0]  mag;
	logic [LEN_W-1:0]        len4;
	logic [CHARS_W-1:0]      chars64;

	mode_t                   idl_mode;
	logic [NUMBER_BITS-1:0]  idl_acc;
	logic [8*NAME_CHARS-1:0] idl_nbuf;
	logic [CNT_W-1:0]        idl_cnt;
	token_t                  q;
	logic                    q_en;

	token_t                  p;
	logic                    p_en;
	logic                    take_idle;

	assign digit   = NUMBER_BITS'(ch[3:0]);
	assign lc      = is_alpha(ch) ? (ch | CASE_BIT) : ch;
	assign mag     = neg ? (~acc + 1'b1) : acc;
	assign len4    = LEN_W'(ncnt);
	assign chars64 = CHARS_W'(nbuf);

	// character with nothing pending
	always_comb begin
		idl_mode = MODE_IDLE;
		idl_acc  = '0;
		idl_nbuf = '0;
		idl_cnt  = '0;
		q        = '0;
		q_en     = 1'b0;
		if (ch == CH_NUL) begin
			q.kind = KIND_END;
			q_en   = 1'b1;
		end else if (is_space(ch)) begin
			q_en = 1'b0;
		end else if (is_digit(ch)) begin
			idl_mode = MODE_NUMBER;
			idl_acc  = digit;
		end else if (is_alpha(ch)) begin
			idl_mode      = MODE_NAME;
			idl_nbuf[7:0] = lc;
			idl_cnt       = CNT_W'(1);
		end else begin
			unique case (ch)
				CH_MINUS: idl_mode = MODE_MINUS;
				CH_LT:    idl_mode = MODE_LT;
				CH_GT:    idl_mode = MODE_GT;
				CH_PLUS: begin
					q.kind = KIND_OP; q.op_code = OP_ADD; q_en = 1'b1;
				end
				CH_STAR: begin
					q.kind = KIND_OP; q.op_code = OP_MUL; q_en = 1'b1;
				end
				CH_SLASH: begin
					q.kind = KIND_OP; q.op_code = OP_DIV; q_en = 1'b1;
				end
				CH_EQ: begin
					q.kind = KIND_OP; q.op_code = OP_EQ; q_en = 1'b1;
				end
				CH_OPEN: begin
					q.kind = KIND_OPEN; q_en = 1'b1;
				end
				CH_CLOSE: begin
					q.kind = KIND_CLOSE; q_en = 1'b1;
				end
				default: begin
					q.kind     = KIND_ERR;
					q.bad_char = ch;
					q_en       = 1'b1;
					idl_mode   = MODE_ERROR;
				end
			endcase
		end
	end

	// pending token and mode update
	always_comb begin
		mode_nxt  = mode;
		acc_nxt   = acc;
		neg_nxt   = neg;
		nbuf_nxt  = nbuf;
		ncnt_nxt  = ncnt;
		novf_nxt  = novf;
		p         = '0;
		p_en      = 1'b0;
		take_idle = 1'b0;
		unique case (mode)
			MODE_NUMBER: begin
				if (is_digit(ch)) begin
					acc_nxt = (acc << 3) + (acc << 1) + digit;
				end else begin
					p.kind    = KIND_INT;
					p.number  = NUMBER_W'(signed'(mag));
					p_en      = 1'b1;
					take_idle = 1'b1;
				end
			end
			MODE_NAME: begin
				if (is_alpha(ch) || is_digit(ch)) begin
					if (ncnt < CNT_W'(NAME_CHARS)) begin
						for (int i = 0; i < NAME_CHARS; i++) begin
							if (ncnt == CNT_W'(i)) begin
								nbuf_nxt[8*i +: 8] = lc;
							end
						end
						ncnt_nxt = ncnt + 1'b1;
					end else begin
						novf_nxt = 1'b1;
					end
				end else begin
					p.kind           = KIND_NAME;
					p.name_chars     = chars64;
					p.name_length    = len4;
					p.name_truncated = novf;
					p.keyword        = novf ? KW_NONE : keyword_of(chars64, len4);
					p_en             = 1'b1;
					take_idle        = 1'b1;
				end
			end
			MODE_MINUS: begin
				if (is_digit(ch)) begin
					mode_nxt = MODE_NUMBER;
					acc_nxt  = digit;
					neg_nxt  = 1'b1;
				end else begin
					p.kind    = KIND_OP;
					p.op_code = OP_SUB;
					p_en      = 1'b1;
					take_idle = 1'b1;
				end
			end
			MODE_LT, MODE_GT: begin
				p.kind = KIND_OP;
				p_en   = 1'b1;
				if (ch == CH_EQ) begin
					p.op_code = (mode == MODE_LT) ? OP_LE : OP_GE;
					mode_nxt  = MODE_IDLE;
					acc_nxt   = '0;
					neg_nxt   = 1'b0;
					nbuf_nxt  = '0;
					ncnt_nxt  = '0;
					novf_nxt  = 1'b0;
				end else begin
					p.op_code = (mode == MODE_LT) ? OP_LT : OP_GT;
					take_idle = 1'b1;
				end
			end
			MODE_ERROR: begin
				if (ch == CH_NUL) begin
					p.kind   = KIND_END;
					p_en     = 1'b1;
					mode_nxt = MODE_IDLE;
					acc_nxt  = '0;
					neg_nxt  = 1'b0;
					nbuf_nxt = '0;
					ncnt_nxt = '0;
					novf_nxt = 1'b0;
				end
			end
			default: begin
				take_idle = 1'b1;
			end
		endcase
		if (take_idle) begin
			mode_nxt = idl_mode;
			acc_nxt  = idl_acc;
			neg_nxt  = 1'b0;
			nbuf_nxt = idl_nbuf;
			ncnt_nxt = idl_cnt;
			novf_nxt = 1'b0;
		end
	end

	// order the tokens and mark the final one
	always_comb begin
		res_n = {1'b0, p_en} + {1'b0, take_idle & q_en};
		res0  = p_en ? p : q;
		res1  = q;
		if (res_n == 2'd2) begin
			res1.last = 1'b1;
		end else begin
			res0.last = 1'b1;
		end
	end

endmodule

### design/ltl_queue.sv
// ----------------------------------------------------------------------------
// ltl_queue: token queue
// Register file of tokens; takes up to two per cycle, hands out one.
// ----------------------------------------------------------------------------
module ltl_queue import ltl_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  token_t           wr0,
	input  token_t           wr1,
	output logic [CNT_W-1:0] level,
	ltl_stream_if.source     token
);

	token_t           mem [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign pop         = token.valid & token.ready;
	assign token.valid = (cnt_q != '0);
	assign token.data  = mem[rp_q];
	assign level       = cnt_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wp_q] <= wr0;
		end
		if (push_n == 2'd2) begin
			mem[PTR_W'(wp_q + 1'b1)] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= PTR_W'(wp_q + push_n);
			rp_q  <= PTR_W'(rp_q + pop);
			cnt_q <= CNT_W'(cnt_q + push_n - pop);
		end
	end

endmodule

### design/lisp_token_lexer.sv
// ----------------------------------------------------------------------------
// lisp_token_lexer: streaming tokenizer for a small Lisp dialect
// Takes one character per request and hands out the tokens it completes.
// ----------------------------------------------------------------------------
//
//  port    role    payload   per request
//  ------  ------  --------  ------------------------------------------------
//  text    sink    text_t    one ASCII character, zero ends the text
//  token   source  token_t   one token; last marks the final one of a char
//
// One character a cycle unless text.ready holds it back: each character is
// registered, then the step logic (multiply by ten, name append, keyword
// compare) runs in the next cycle and writes zero, one or two tokens into
// an eight-entry token queue. text.ready drops only while the queue could
// not take two more tokens for each character in flight; a stalled token
// side never blocks the step. Reset clears the lexer state and the queue;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module lisp_token_lexer import ltl_pkg::*; #(
	parameter int NAME_CHARS  = NAME_CHARS_DEF,
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ltl_stream_if.sink   text,
	ltl_stream_if.source token
);

	localparam int CNT_W   = $clog2(NAME_CHARS + 1);
	localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

	// input stage
	logic                    valid_s1;
	logic [CHAR_W-1:0]       ch_s1;

	// lexer state
	mode_t                   mode_q;
	logic [NUMBER_BITS-1:0]  acc_q;
	logic                    neg_q;
	logic [8*NAME_CHARS-1:0] nbuf_q;
	logic [CNT_W-1:0]        ncnt_q;
	logic                    novf_q;

	mode_t                   mode_nxt;
	logic [NUMBER_BITS-1:0]  acc_nxt;
	logic                    neg_nxt;
	logic [8*NAME_CHARS-1:0] nbuf_nxt;
	logic [CNT_W-1:0]        ncnt_nxt;
	logic                    novf_nxt;

	token_t                  res0;
	token_t                  res1;
	logic [1:0]              res_n;
	logic [1:0]              push_n;
	logic [LEVEL_W-1:0]      level;
	logic [LEVEL_W:0]        committed;

	// Hold back a new character unless the queue keeps two free slots for it
	// and two more for the character already in the input stage.
	assign committed  = {1'b0, level} + (valid_s1 ? (LEVEL_W + 1)'(2) : '0);
	assign text.ready = (committed <= (LEVEL_W + 1)'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= text.valid & text.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			ch_s1 <= text.data.ch;
		end
	end

	ltl_step #(
		.NAME_CHARS  (NAME_CHARS),
		.NUMBER_BITS (NUMBER_BITS)
	) u_step (
		.ch       (ch_s1),
		.mode     (mode_q),
		.acc      (acc_q),
		.neg      (neg_q),
		.nbuf     (nbuf_q),
		.ncnt     (ncnt_q),
		.novf     (novf_q),
		.mode_nxt (mode_nxt),
		.acc_nxt  (acc_nxt),
		.neg_nxt  (neg_nxt),
		.nbuf_nxt (nbuf_nxt),
		.ncnt_nxt (ncnt_nxt),
		.novf_nxt (novf_nxt),
		.res0     (res0),
		.res1     (res1),
		.res_n    (res_n)
	);

	// Advance the lexer state only on a character in the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			neg_q  <= 1'b0;
			nbuf_q <= '0;
			ncnt_q <= '0;
			novf_q <= 1'b0;
		end else if (valid_s1) begin
			mode_q <= mode_nxt;
			acc_q  <= acc_nxt;
			neg_q  <= neg_nxt;
			nbuf_q <= nbuf_nxt;
			ncnt_q <= ncnt_nxt;
			novf_q <= novf_nxt;
		end
	end

	assign push_n = valid_s1 ? res_n : 2'd0;

	ltl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.wr0    (res0),
		.wr1    (res1),
		.level  (level),
		.token  (token)
	);

	// the queue always has room for the tokens of the staged character
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({1'b0, level} + (LEVEL_W + 1)'(2)) <= (LEVEL_W + 1)'(QUEUE_DEPTH))
		else $error("token queue overrun");

	// end of text returns the lexer to its reset state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ch_s1 == CH_NUL) |=>
			(mode_q == MODE_IDLE && acc_q == '0 && ncnt_q == '0 && !neg_q && !novf_q))
		else $error("state not cleared at end of text");

	// an end token is always the final token of its character
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token.valid && token.data.kind == KIND_END) |-> token.data.last)
		else $error("end token not marked last");

endmodule

### test/ltl_token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ltl_token_checker: token predictor and comparator for the Lisp lexer
// Watches both channels, works out the tokens each accepted character must
// give, and checks every token that leaves the block against the oldest one.
// ----------------------------------------------------------------------------
module ltl_token_checker import ltl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   text_valid,
	input  logic   text_ready,
	input  text_t  text_data,
	input  logic   token_valid,
	input  logic   token_ready,
	input  token_t token_data,
	output int     mismatches,
	output int     pending_tokens,
	output int     tokens_checked
);

	mode_t               lex_mode_q;
	logic [NUMBER_W-1:0] digits_acc;
	logic                minus_seen;
	logic [CHARS_W-1:0]  name_buf;
	logic [LEN_W-1:0]    name_cnt;
	logic                name_cut;

	token_t step_tokens[$];
	token_t expected_tokens[$];
	token_t want;

	function automatic logic char_digit(input logic [CHAR_W-1:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic char_letter(input logic [CHAR_W-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic char_blank(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic token_t blank_token(input logic [KIND_W-1:0] kind);
		token_t t;
		t = '0;
		t.kind = kind;
		return t;
	endfunction

	function automatic void push_kind(input logic [KIND_W-1:0] kind);
		step_tokens.push_back(blank_token(kind));
	endfunction

	function automatic void push_op(input logic [OP_W-1:0] op);
		token_t t;
		t = blank_token(KIND_OP);
		t.op_code = op;
		step_tokens.push_back(t);
	endfunction

	function automatic void push_number();
		token_t t;
		t = blank_token(KIND_INT);
		t.number = minus_seen ? 32'd0 - digits_acc : digits_acc;
		step_tokens.push_back(t);
	endfunction

	function automatic void push_name();
		token_t t;
		t = blank_token(KIND_NAME);
		t.name_chars = name_buf;
		t.name_length = name_cnt;
		t.name_truncated = name_cut;
		t.keyword = KW_NONE;
		// a cut name is never a keyword
		if (!name_cut) begin
			case (name_cnt)
				4'd1: if (name_buf == KW_T_CHARS) t.keyword = KW_T;
				4'd2: if (name_buf == KW_IF_CHARS) t.keyword = KW_IF;
				4'd3: if (name_buf == KW_NIL_CHARS) t.keyword = KW_NIL;
				4'd4: if (name_buf == KW_SETQ_CHARS) t.keyword = KW_SETQ;
				4'd5: if (name_buf == KW_DEFUN_CHARS) t.keyword = KW_DEFUN;
				default: t.keyword = KW_NONE;
			endcase
		end
		step_tokens.push_back(t);
	endfunction

	function automatic void lex_clear();
		lex_mode_q = MODE_IDLE;
		digits_acc = '0;
		minus_seen = 1'b0;
		name_buf = '0;
		name_cnt = '0;
		name_cut = 1'b0;
	endfunction

	// character seen with no token open
	function automatic void start_token(input logic [CHAR_W-1:0] c);
		token_t t;
		lex_clear();
		if (c == CH_NUL) begin
			push_kind(KIND_END);
		end else if (char_blank(c)) begin
			// skip whitespace
		end else if (char_digit(c)) begin
			lex_mode_q = MODE_NUMBER;
			digits_acc = {24'h0, c - CH_ZERO};
		end else if (char_letter(c)) begin
			lex_mode_q = MODE_NAME;
			name_buf = {56'h0, c | CASE_BIT};
			name_cnt = 4'd1;
		end else begin
			case (c)
				CH_MINUS: lex_mode_q = MODE_MINUS;
				CH_LT:    lex_mode_q = MODE_LT;
				CH_GT:    lex_mode_q = MODE_GT;
				CH_PLUS:  push_op(OP_ADD);
				CH_STAR:  push_op(OP_MUL);
				CH_SLASH: push_op(OP_DIV);
				CH_EQ:    push_op(OP_EQ);
				CH_OPEN:  push_kind(KIND_OPEN);
				CH_CLOSE: push_kind(KIND_CLOSE);
				default: begin
					t = blank_token(KIND_ERR);
					t.bad_char = c;
					step_tokens.push_back(t);
					lex_mode_q = MODE_ERROR;
				end
			endcase
		end
	endfunction

	// advance the lexer by one character and queue the tokens it completes
	function automatic void lex_character(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] lc;
		token_t t;
		step_tokens.delete();
		case (lex_mode_q)
			MODE_NUMBER: begin
				if (char_digit(c)) begin
					digits_acc = digits_acc * 32'd10 + {24'h0, c - CH_ZERO};
				end else begin
					push_number();
					start_token(c);
				end
			end
			MODE_NAME: begin
				if (char_letter(c) || char_digit(c)) begin
					lc = char_letter(c) ? (c | CASE_BIT) : c;
					if (name_cnt < NAME_CHARS_DEF) begin
						name_buf = name_buf | ({56'h0, lc} << (8 * name_cnt));
						name_cnt = name_cnt + 4'd1;
					end else begin
						name_cut = 1'b1;
					end
				end else begin
					push_name();
					start_token(c);
				end
			end
			MODE_MINUS: begin
				if (char_digit(c)) begin
					lex_mode_q = MODE_NUMBER;
					digits_acc = {24'h0, c - CH_ZERO};
					minus_seen = 1'b1;
				end else begin
					push_op(OP_SUB);
					start_token(c);
				end
			end
			MODE_LT: begin
				if (c == CH_EQ) begin
					push_op(OP_LE);
					lex_clear();
				end else begin
					push_op(OP_LT);
					start_token(c);
				end
			end
			MODE_GT: begin
				if (c == CH_EQ) begin
					push_op(OP_GE);
					lex_clear();
				end else begin
					push_op(OP_GT);
					start_token(c);
				end
			end
			MODE_ERROR: begin
				// drop everything up to the end of the text
				if (c == CH_NUL) begin
					push_kind(KIND_END);
					lex_clear();
				end
			end
			default: start_token(c);
		endcase
		foreach (step_tokens[i]) begin
			t = step_tokens[i];
			t.last = (i == step_tokens.size() - 1);
			expected_tokens.push_back(t);
		end
	endfunction

	function automatic string token_text(input token_t t);
		return $sformatf("kind %0d num %0d op %0d chars %h len %0d cut %0b kw %0d bad %h last %0b",
			t.kind, t.number, t.op_code, t.name_chars, t.name_length, t.name_truncated,
			t.keyword, t.bad_char, t.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_clear();
			expected_tokens.delete();
			mismatches = 0;
			tokens_checked = 0;
		end else begin
			if (text_valid && text_ready) begin
				lex_character(text_data.ch);
			end
			if (token_valid && token_ready) begin
				tokens_checked++;
				if (expected_tokens.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t unexpected token: %s", $time, token_text(token_data));
					end
				end else begin
					want = expected_tokens.pop_front();
					if (token_data.kind !== want.kind || token_data.number !== want.number ||
							token_data.op_code !== want.op_code ||
							token_data.name_chars !== want.name_chars ||
							token_data.name_length !== want.name_length ||
							token_data.name_truncated !== want.name_truncated ||
							token_data.keyword !== want.keyword ||
							token_data.bad_char !== want.bad_char ||
							token_data.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t token mismatch", $time);
							$display("  expected %s", token_text(want));
							$display("  actual   %s", token_text(token_data));
						end
					end
				end
			end
		end
		pending_tokens = expected_tokens.size();
	end

endmodule

### test/tb_lisp_token_lexer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lisp_token_lexer: stimulus and verdict for the Lisp token lexer
// Feeds directed and random texts, mostly well-formed Lisp with random
// content plus noise and broken texts, with random gaps on the character
// side and random stalls on the token side; a checker beside the block
// predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_lisp_token_lexer import ltl_pkg::*; ();

	// characters to send in the random part
	localparam int CHAR_TARGET   = 1800;
	// run limit in cycles, far beyond the slowest correct run
	localparam int CYCLE_LIMIT   = 1_000_000;
	// quiet cycles after the last token, to catch stray tokens
	localparam int SETTLE_CYCLES = 64;

	logic clk;
	logic arst_n;

	int cycles = 0;
	int chars_sent = 0;
	int texts_sent = 0;
	bit calm = 1'b0;

	int mismatches;
	int pending_tokens;
	int tokens_checked;

	// the text being built, sent as one request per character
	logic [CHAR_W-1:0] text_chars[$];

	string op_spellings[9] = '{"+", "-", "*", "/", "=", "<", "<=", ">", ">="};
	string kw_spellings[5] = '{"if", "t", "nil", "setq", "defun"};

	ltl_stream_if #(.payload_t(text_t))  text_ch ();
	ltl_stream_if #(.payload_t(token_t)) token_ch ();

	lisp_token_lexer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.token  (token_ch)
	);

	ltl_token_checker token_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_valid     (text_ch.valid),
		.text_ready     (text_ch.ready),
		.text_data      (text_ch.data),
		.token_valid    (token_ch.valid),
		.token_ready    (token_ch.ready),
		.token_data     (token_ch.data),
		.mismatches     (mismatches),
		.pending_tokens (pending_tokens),
		.tokens_checked (tokens_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// Idle length for either side: mostly none, some short, a few long.
	// Hold at zero during a calm stretch.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Send one character; return at the edge that accepts the request.
	// Sample ready at the falling edge so that the result does not hang on
	// event order at the rising one.
	task automatic send_char(input logic [CHAR_W-1:0] c);
		int gap;
		bit took;
		gap = pick_gap();
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data.ch <= c;
		do begin
			@(negedge clk);
			took = text_ch.ready;
			@(posedge clk);
		end while (!took);
		chars_sent++;
	endtask

	task automatic send_text();
		foreach (text_chars[i]) send_char(text_chars[i]);
		text_chars.delete();
		texts_sent++;
	endtask

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_letter();
		logic [CHAR_W-1:0] c;
		c = 8'h61 + 8'($urandom_range(0, 25));
		if ($urandom_range(0, 2) == 0) c = c & ~CASE_BIT;
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// space, tab, LF, VT, FF or CR
	function automatic logic [CHAR_W-1:0] rand_blank();
		if ($urandom_range(0, 5) == 5) return CH_SPACE;
		return CH_TAB + 8'($urandom_range(0, 4));
	endfunction

	// a character that no token accepts
	function automatic logic [CHAR_W-1:0] rand_junk();
		case ($urandom_range(0, 8))
			0: return 8'($urandom_range(1, 8));
			1: return 8'($urandom_range(14, 31));
			2: return 8'($urandom_range(33, 39));
			3: return 8'($urandom_range(58, 59));
			4: return 8'($urandom_range(63, 64));
			5: return 8'($urandom_range(91, 96));
			6: return 8'($urandom_range(123, 127));
			7: return 8'h2C + 8'(2 * $urandom_range(0, 1));
			default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	function automatic void add_lexeme();
		string s;
		logic [CHAR_W-1:0] c;
		int n;
		case ($urandom_range(0, 9))
			0, 1: begin
				// mostly short numbers, now and then long enough to wrap
				if ($urandom_range(0, 2) == 0) text_chars.push_back(CH_MINUS);
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
				repeat (n) text_chars.push_back(rand_digit());
			end
			2, 3: begin
				text_chars.push_back(rand_letter());
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 11) : $urandom_range(0, 4);
				repeat (n) begin
					text_chars.push_back(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
				end
			end
			4: begin
				// keyword in mixed case
				s = kw_spellings[$urandom_range(0, 4)];
				for (int i = 0; i < s.len(); i++) begin
					c = s[i];
					if ($urandom_range(0, 3) == 0) c = c & ~CASE_BIT;
					text_chars.push_back(c);
				end
			end
			5, 6, 7: add_str(op_spellings[$urandom_range(0, 8)]);
			8: text_chars.push_back(CH_OPEN);
			default: text_chars.push_back(CH_CLOSE);
		endcase
	endfunction

	// One text ending in zero: mostly well-formed, sometimes with an unknown
	// character inside, and now and then pure noise.
	task automatic send_random_text();
		int n;
		calm = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 12);
			repeat (n) text_chars.push_back(8'($urandom_range(1, 255)));
		end else begin
			n = $urandom_range(0, 10);
			repeat (n) begin
				add_lexeme();
				if ($urandom_range(0, 9) < 6) begin
					repeat ($urandom_range(1, 2)) text_chars.push_back(rand_blank());
				end
				if ($urandom_range(0, 39) == 0) text_chars.push_back(rand_junk());
			end
		end
		text_chars.push_back(CH_NUL);
		send_text();
	endtask

	// token side: ready in runs, broken by stalls of random length
	initial begin
		int gap;
		token_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				token_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			token_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d tokens still expected", cycles, pending_tokens);
		$display("tb: failure");
		$finish;
	end

	initial begin
		text_ch.valid <= 1'b0;
		text_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts: parens, keywords in upper case, a negative number,
		// both relational pairs, then every single-character operator with a
		// lone minus and lone < and >, a name closed by the end of text, and
		// an unknown character that drops the rest of its text.
		add_str("(IF -3<=t>=nil)");
		text_chars.push_back(CH_NUL);
		send_text();
		add_str("+*/=-<>a");
		text_chars.push_back(CH_NUL);
		send_text();
		text_chars.push_back(8'hFF);
		add_str("b");
		text_chars.push_back(CH_NUL);
		send_text();

		while (chars_sent < CHAR_TARGET) send_random_text();
		text_ch.valid <= 1'b0;

		// drain, then keep the token side open to catch anything extra
		@(negedge clk);
		wait (pending_tokens == 0);
		calm = 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d texts of %0d characters in all, %0d tokens checked",
			texts_sent, chars_sent, tokens_checked);
		$display("mismatches %0d, tokens still expected %0d", mismatches, pending_tokens);
		if (mismatches == 0 && pending_tokens == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
